>>> design/vcb_pkg.sv
// Package with shared types, constants and codes of the cell balancing controller.
`default_nettype none
package vcb_pkg;
    localparam int NUM_STRINGS_DEF        = 2;
    localparam int MODULES_PER_STRING_DEF = 4;
    localparam int CELLS_PER_MODULE_DEF   = 16;

    localparam logic [2:0] REQ_WRITE_CELL = 3'd0;
    localparam logic [2:0] REQ_WRITE_STR  = 3'd1;
    localparam logic [2:0] REQ_REQUEST    = 3'd2;
    localparam logic [2:0] REQ_TICK       = 3'd3;
    localparam logic [2:0] REQ_READ       = 3'd4;

    localparam logic [1:0] CODE_NONE   = 2'd0;
    localparam logic [1:0] CODE_ALLOW  = 2'd1;
    localparam logic [1:0] CODE_FORBID = 2'd2;

    localparam logic       ST_CHECK   = 1'b0;
    localparam logic       ST_BALANCE = 1'b1;
    localparam logic [1:0] SUB_ENTRY  = 2'd0;
    localparam logic [1:0] SUB_VOLT   = 2'd1;
    localparam logic [1:0] SUB_REST   = 2'd2;
    localparam logic [1:0] SUB_ACT    = 2'd3;

    localparam logic [2:0] REG_BASE  = 3'd0;
    localparam logic [2:0] REG_HYST  = 3'd1;
    localparam logic [2:0] REG_LOWV  = 3'd2;
    localparam logic [2:0] REG_UPT   = 3'd3;
    localparam logic [2:0] REG_SHORT = 3'd4;
    localparam logic [2:0] REG_BWAIT = 3'd5;

    typedef struct packed {
        logic [2:0]         req_type;
        logic               string_index;
        logic [1:0]         module_index;
        logic [3:0]         cell_index;
        logic signed [15:0] voltage_mv;
        logic signed [15:0] temperature_ddegc;
        logic [1:0]         request_code;
        logic               at_rest;
        logic               global_allowed;
    } vcb_in_t;

    typedef struct packed {
        logic        fsm_state;
        logic [1:0]  substate;
        logic        balancing_active;
        logic        balancing_enabled;
        logic [15:0] activation_bits;
        logic [6:0]  balanced_count;
    } vcb_out_t;

    typedef struct packed {
        logic [11:0]        base_threshold_mv;
        logic [11:0]        hysteresis_mv;
        logic signed [15:0] lower_voltage_limit_mv;
        logic signed [15:0] upper_temp_limit_ddegc;
        logic [7:0]         short_wait_ticks;
        logic [7:0]         balance_wait_ticks;
    } vcb_cfg_t;
endpackage
`default_nettype wire

>>> design/vcb_if.sv
// Valid/ready channel interface carrying one word.
`default_nettype none
interface vcb_if #(parameter type word_t = logic);
    logic  valid;
    logic  ready;
    word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/vcb_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module vcb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

>>> design/vcb_cfg.sv
// APB-style configuration register file.
`default_nettype none
module vcb_cfg (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [4:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic      [31:0]     prdata,
    output logic                 pready,
    output vcb_pkg::vcb_cfg_t    cfg
);
    import vcb_pkg::*;
    vcb_cfg_t   cfg_reg;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_threshold_mv      <= 12'd10;
            cfg_reg.hysteresis_mv          <= 12'd200;
            cfg_reg.lower_voltage_limit_mv <= 16'sd1500;
            cfg_reg.upper_temp_limit_ddegc <= 16'sd700;
            cfg_reg.short_wait_ticks       <= 8'd1;
            cfg_reg.balance_wait_ticks     <= 8'd10;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_BASE:  cfg_reg.base_threshold_mv      <= pwdata[11:0];
                REG_HYST:  cfg_reg.hysteresis_mv          <= pwdata[11:0];
                REG_LOWV:  cfg_reg.lower_voltage_limit_mv <= pwdata[15:0];
                REG_UPT:   cfg_reg.upper_temp_limit_ddegc <= pwdata[15:0];
                REG_SHORT: cfg_reg.short_wait_ticks       <= pwdata[7:0];
                REG_BWAIT: cfg_reg.balance_wait_ticks     <= pwdata[7:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        unique case (idx)
            REG_BASE:  prdata = {20'd0, cfg_reg.base_threshold_mv};
            REG_HYST:  prdata = {20'd0, cfg_reg.hysteresis_mv};
            REG_LOWV:  prdata = {16'd0, cfg_reg.lower_voltage_limit_mv};
            REG_UPT:   prdata = {16'd0, cfg_reg.upper_temp_limit_ddegc};
            REG_SHORT: prdata = {24'd0, cfg_reg.short_wait_ticks};
            REG_BWAIT: prdata = {24'd0, cfg_reg.balance_wait_ticks};
            default:   prdata = 32'd0;
        endcase
    end
endmodule
`default_nettype wire

>>> design/voltage_cell_balancing_controller.sv
// Top level of the voltage-threshold passive cell balancing controller.
// A voltage write, string write, request, read or other tick passes the exec, read and
// out states to a result; an activating tick walks every stored cell through one shared
// comparator, one cell per cycle, in the scan state, then passes the fin, read and out states.
// One word is in work at a time; the next is accepted once the result is taken.
// Reset (rst_n, asynchronous) enters the check state; the cell store is cleared by a
// sweep of one entry per cycle over every entry before the first word is accepted.
`default_nettype none
module voltage_cell_balancing_controller #(
    parameter int NUM_STRINGS        = vcb_pkg::NUM_STRINGS_DEF,
    parameter int MODULES_PER_STRING = vcb_pkg::MODULES_PER_STRING_DEF,
    parameter int CELLS_PER_MODULE   = vcb_pkg::CELLS_PER_MODULE_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    vcb_if.sink              in_ch,
    vcb_if.source            out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import vcb_pkg::*;

    localparam int CPS   = MODULES_PER_STRING * CELLS_PER_MODULE;
    localparam int TOTAL = NUM_STRINGS * CPS;
    localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int SW    = (NUM_STRINGS > 1) ? $clog2(NUM_STRINGS) : 1;
    localparam int KW    = (CPS > 1) ? $clog2(CPS) : 1;

    // Sequencer states.
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    vcb_cfg_t cfg;
    vcb_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    // Cell voltage memory; activation marks live in flip-flops (read 16 at a time).
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [15:0]   ram_wdata, ram_rdata;
    vcb_ram #(.WIDTH(16), .DEPTH(TOTAL)) u_volt (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    logic [2:0]        seq_reg, seq_next;
    vcb_in_t           in_reg;
    logic [TOTAL-1:0]  act_reg;
    logic signed [15:0] smin_reg [NUM_STRINGS];
    logic signed [15:0] stemp_reg [NUM_STRINGS];
    logic [6:0]        scnt_reg [NUM_STRINGS];
    logic              fsm_reg;
    logic [1:0]        sub_reg;
    logic [7:0]        timer_reg;
    logic [12:0]       thr_reg;
    logic [1:0]        pend_reg;
    logic              local_reg, active_reg, enable_reg;
    logic [AW:0]       ptr_reg;      // address being issued
    logic [AW:0]       cmp_reg;      // address whose data is arriving
    logic [SW-1:0]     cmp_str_reg;  // string of the cell whose data is arriving
    logic [KW-1:0]     cmp_k_reg;    // position of that cell within its string
    logic              cmp_vld_reg;
    logic              done_reg;
    logic [6:0]        cnt_reg;
    vcb_out_t          out_reg;

    logic s_ok, m_ok, c_ok;
    assign s_ok = 32'(in_reg.string_index) < NUM_STRINGS;
    assign m_ok = 32'(in_reg.module_index) < MODULES_PER_STRING;
    assign c_ok = 32'(in_reg.cell_index) < CELLS_PER_MODULE;

    logic [AW-1:0] wr_addr;
    assign wr_addr = AW'(32'(in_reg.string_index) * CPS
                   + 32'(in_reg.module_index) * CELLS_PER_MODULE
                   + 32'(in_reg.cell_index));

    // Scan comparison: one cell per cycle through the shared comparator.
    logic [SW-1:0]      cmp_str;
    logic [KW-1:0]      cmp_k;
    logic signed [17:0] lim;
    logic               hit;
    assign cmp_str = cmp_str_reg;
    assign cmp_k   = cmp_k_reg;
    assign lim     = 18'(smin_reg[cmp_str]) + 18'($signed({1'b0, thr_reg}));
    assign hit     = 18'(signed'(ram_rdata)) > lim;

    // Tick decision computed combinationally from current machine state.
    logic [1:0] req_eff;
    logic       loc_eff, run, limit_hit;
    always_comb
    begin
        limit_hit = 1'b0;
        for (int s = 0; s < NUM_STRINGS; s++)
        begin
            if (smin_reg[s] <= cfg.lower_voltage_limit_mv ||
                stemp_reg[s] >= cfg.upper_temp_limit_ddegc)
            begin
                limit_hit = 1'b1;
            end
        end
    end
    assign run     = (timer_reg <= 8'd1);
    assign req_eff = pend_reg;
    assign loc_eff = (req_eff == CODE_FORBID) ? 1'b0 :
                     (req_eff == CODE_ALLOW) ? 1'b1 : local_reg;

    assign in_ch.ready  = (seq_reg == S_IDLE);
    assign out_ch.valid = (seq_reg == S_OUT);
    assign out_ch.data  = out_reg;

    always_comb
    begin
        seq_next = seq_reg;
        unique case (seq_reg)
            S_CLEAR: if (ptr_reg == (AW+1)'(TOTAL - 1)) seq_next = S_IDLE;
            S_IDLE:  if (in_ch.valid) seq_next = S_EXEC;
            S_EXEC:
            begin
                if (in_reg.req_type == REQ_TICK && run && fsm_reg == ST_BALANCE &&
                    in_reg.global_allowed && sub_reg == SUB_ACT && loc_eff)
                begin
                    seq_next = S_SCAN;
                end
                else
                begin
                    seq_next = S_READ;
                end
            end
            S_SCAN:  if (cmp_vld_reg && cmp_reg == (AW+1)'(TOTAL - 1)) seq_next = S_FIN;
            S_FIN:   seq_next = S_READ;
            S_READ:  seq_next = S_OUT;
            S_OUT:   if (out_ch.ready) seq_next = S_IDLE;
            default: seq_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = ptr_reg[AW-1:0];
        ram_wdata = in_reg.voltage_mv;
        if (seq_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_wdata = 16'd0;
        end
        else if (seq_reg == S_EXEC && in_reg.req_type == REQ_WRITE_CELL && s_ok && m_ok && c_ok)
        begin
            ram_we   = 1'b1;
            ram_addr = wr_addr;
        end
    end

    // Marks of the addressed module and the balanced count of its string, gathered for the result.
    logic [15:0] bits;
    logic [6:0]  rcnt;
    always_comb
    begin
        bits = 16'd0;
        rcnt = 7'd0;
        if (s_ok)
        begin
            rcnt = scnt_reg[SW'(in_reg.string_index)];
            if (m_ok)
            begin
                for (int k = 0; k < CELLS_PER_MODULE; k++)
                begin
                    bits[k] = act_reg[32'(in_reg.string_index) * CPS
                                      + 32'(in_reg.module_index) * CELLS_PER_MODULE + k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_reg == S_IDLE && in_ch.valid)
        begin
            in_reg <= in_ch.data;
        end
        if (seq_reg == S_READ)
        begin
            out_reg.fsm_state         <= fsm_reg;
            out_reg.substate          <= sub_reg;
            out_reg.balancing_active  <= active_reg;
            out_reg.balancing_enabled <= enable_reg;
            out_reg.activation_bits   <= bits;
            out_reg.balanced_count    <= rcnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg     <= S_CLEAR;
            act_reg     <= '0;
            for (int s = 0; s < NUM_STRINGS; s++)
            begin
                smin_reg[s]  <= '0;
                stemp_reg[s] <= '0;
                scnt_reg[s]  <= '0;
            end
            fsm_reg     <= ST_CHECK;
            sub_reg     <= SUB_ENTRY;
            timer_reg   <= '0;
            thr_reg     <= 13'd210;
            pend_reg    <= CODE_NONE;
            local_reg   <= 1'b1;
            active_reg  <= 1'b0;
            enable_reg  <= 1'b0;
            ptr_reg     <= '0;
            cmp_reg     <= '0;
            cmp_str_reg <= '0;
            cmp_k_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            seq_reg <= seq_next;
            unique case (seq_reg)
                S_CLEAR:
                begin
                    ptr_reg <= (ptr_reg == (AW+1)'(TOTAL - 1)) ? '0 : ptr_reg + 1'b1;
                end
                S_EXEC:
                begin
                    ptr_reg     <= '0;
                    cmp_str_reg <= '0;
                    cmp_k_reg   <= '0;
                    cmp_vld_reg <= 1'b0;
                    done_reg    <= 1'b1;
                    cnt_reg     <= '0;
                    priority case (in_reg.req_type)
                        REQ_WRITE_STR:
                            if (s_ok)
                            begin
                                smin_reg[SW'(in_reg.string_index)]  <= in_reg.voltage_mv;
                                stemp_reg[SW'(in_reg.string_index)] <= in_reg.temperature_ddegc;
                            end
                        REQ_REQUEST:
                            if (in_reg.request_code != 2'd3) pend_reg <= in_reg.request_code;
                        REQ_TICK:
                        begin
                            if (!run)
                            begin
                                timer_reg <= timer_reg - 8'd1;
                            end
                            else
                            begin
                                pend_reg  <= CODE_NONE;
                                local_reg <= loc_eff;
                                if (fsm_reg == ST_CHECK)
                                begin
                                    timer_reg <= cfg.short_wait_ticks;
                                    if (!loc_eff || !in_reg.global_allowed)
                                    begin
                                        act_reg    <= '0;
                                        enable_reg <= 1'b0;
                                        active_reg <= 1'b0;
                                        for (int s = 0; s < NUM_STRINGS; s++)
                                            scnt_reg[s] <= '0;
                                    end
                                    else if (in_reg.at_rest)
                                    begin
                                        fsm_reg <= ST_BALANCE;
                                        sub_reg <= SUB_ENTRY;
                                    end
                                end
                                else if (!in_reg.global_allowed ||
                                         (sub_reg == SUB_ENTRY && !loc_eff) ||
                                         (sub_reg == SUB_VOLT && limit_hit) ||
                                         (sub_reg == SUB_REST && !in_reg.at_rest) ||
                                         (sub_reg == SUB_ACT && !loc_eff))
                                begin
                                    // Exit to check; deactivate if active.
                                    if (active_reg)
                                    begin
                                        act_reg    <= '0;
                                        enable_reg <= 1'b0;
                                        for (int s = 0; s < NUM_STRINGS; s++)
                                            scnt_reg[s] <= '0;
                                    end
                                    active_reg <= 1'b0;
                                    fsm_reg    <= ST_CHECK;
                                    sub_reg    <= SUB_ENTRY;
                                    timer_reg  <= (!in_reg.global_allowed ||
                                                   sub_reg == SUB_ENTRY) ?
                                                  cfg.short_wait_ticks : cfg.balance_wait_ticks;
                                end
                                else
                                begin
                                    unique case (sub_reg)
                                        SUB_ENTRY:
                                        begin
                                            sub_reg   <= SUB_VOLT;
                                            timer_reg <= cfg.short_wait_ticks;
                                        end
                                        SUB_VOLT:
                                        begin
                                            sub_reg   <= SUB_REST;
                                            timer_reg <= cfg.balance_wait_ticks;
                                        end
                                        SUB_REST:
                                        begin
                                            sub_reg   <= SUB_ACT;
                                            timer_reg <= cfg.balance_wait_ticks;
                                        end
                                        default:
                                        begin
                                            timer_reg <= cfg.balance_wait_ticks;
                                        end
                                    endcase
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                S_SCAN:
                begin
                    if (ptr_reg != (AW+1)'(TOTAL))
                    begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                    cmp_vld_reg <= (ptr_reg != (AW+1)'(TOTAL));
                    cmp_reg     <= ptr_reg;
                    if (cmp_vld_reg)
                    begin
                        act_reg[cmp_reg[AW-1:0]] <= hit;
                        if (hit)
                        begin
                            done_reg   <= 1'b0;
                            thr_reg    <= {1'b0, cfg.base_threshold_mv};
                            active_reg <= 1'b1;
                            enable_reg <= 1'b1;
                        end
                        if (32'(cmp_k) == CPS - 1)
                        begin
                            scnt_reg[cmp_str] <= (hit && cnt_reg != 7'd127) ?
                                                 cnt_reg + 7'd1 : cnt_reg;
                            cnt_reg     <= '0;
                            cmp_k_reg   <= '0;
                            cmp_str_reg <= cmp_str_reg + 1'b1;
                        end
                        else
                        begin
                            cmp_k_reg <= cmp_k_reg + 1'b1;
                            if (hit && cnt_reg != 7'd127)
                            begin
                                cnt_reg <= cnt_reg + 7'd1;
                            end
                        end
                    end
                end
                S_FIN:
                begin
                    sub_reg <= SUB_ENTRY;
                    if (done_reg)
                    begin
                        thr_reg <= 13'(cfg.base_threshold_mv) + 13'(cfg.hysteresis_mv);
                        fsm_reg <= ST_CHECK;
                    end
                    else
                    begin
                        fsm_reg <= ST_BALANCE;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire
